### sv/c32fd_pkg.sv
// c32fd_pkg: shared types, constants and the byte-wide crc-32 update
// for the length-prefixed frame deframer; no dependencies
package c32fd_pkg;

  // width of an accepted payload length
  localparam int unsigned LENGTH_BITS = 24;
  // largest length that fits in LENGTH_BITS bits
  localparam logic [31:0] LEN_LIMIT   = 32'((33'd1 << LENGTH_BITS) - 33'd1);

  localparam int unsigned HDR_BYTES   = 4 + 4 + 1 + 4;
  localparam logic [3:0]  HDR_LAST    = 4'(HDR_BYTES - 1);
  localparam logic [3:0]  CRC_LAST    = 4'd3;

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES    = 32'hFFFFFFFF;

  // configuration register indexes
  localparam logic [1:0] REG_MAGIC    = 2'd0;
  localparam logic [1:0] REG_VERSION  = 2'd1;
  localparam logic [1:0] REG_MAX_LEN  = 2'd2;
  localparam logic [1:0] REG_HI_TYPE  = 2'd3;

  // input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNC_HDR  = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_VER    = 3'd3,
    ST_BAD_TYPE   = 3'd4,
    ST_OVERSIZED  = 3'd5,
    ST_TRUNC_FRM  = 3'd6,
    ST_CRC_ERR    = 3'd7
  } status_e;

  typedef struct packed {
    logic [31:0] frame_magic;
    logic [31:0] protocol_version;
    logic [23:0] max_payload;
    logic [7:0]  highest_type;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  out_byte;
    logic [7:0]  msg_type;
    logic [23:0] payload_length;
    logic        last_payload;
    status_e     status;
  } result_t;

  // reflected crc-32 update by one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/c32fd_cfg_regs.sv
// c32fd_cfg_regs: configuration registers written through a plain write port
// depends on c32fd_pkg
module c32fd_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_data_i,
  output c32fd_pkg::cfg_t    cfg_o
);

  c32fd_pkg::cfg_t cfg_q;

  // register writes, reset to the default frame setup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_magic      <= 32'd0;
      cfg_q.protocol_version <= 32'd1;
      cfg_q.max_payload      <= 24'd65536;
      cfg_q.highest_type     <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        c32fd_pkg::REG_MAGIC:   cfg_q.frame_magic      <= cfg_data_i;
        c32fd_pkg::REG_VERSION: cfg_q.protocol_version <= cfg_data_i;
        c32fd_pkg::REG_MAX_LEN: cfg_q.max_payload      <= cfg_data_i[23:0];
        c32fd_pkg::REG_HI_TYPE: cfg_q.highest_type     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/c32fd_in_stage.sv
// c32fd_in_stage: input register that holds one accepted item for the parser
// depends on c32fd_pkg
module c32fd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  c32fd_pkg::item_t  in_item_i,
  output logic              item_valid_o,
  output c32fd_pkg::item_t  item_o,
  input  logic              advance_i
);

  logic             valid_q;
  c32fd_pkg::item_t item_q;

  // free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload register, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### sv/c32fd_parser.sv
// c32fd_parser: frame state machine, header gathering, crc and checks
// depends on c32fd_pkg
module c32fd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  c32fd_pkg::cfg_t     cfg_i,
  input  logic                advance_i,
  input  c32fd_pkg::item_t    item_i,
  output logic                res_valid_o,
  output c32fd_pkg::result_t  res_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [3:0]                        cnt_q, cnt_d;
  logic [31:0]                       magic_q, magic_d;
  logic [31:0]                       version_q, version_d;
  logic [7:0]                        type_q, type_d;
  logic [31:0]                       length_q, length_d;
  logic [c32fd_pkg::LENGTH_BITS-1:0] left_q, left_d;
  logic [31:0]                       crc_q, crc_d;
  logic [31:0]                       rx_crc_q, rx_crc_d;

  logic [7:0]  b;
  logic [31:0] crc_next;
  logic [31:0] len_full;
  logic [31:0] rx_full;
  logic [1:0]  len_lane;
  logic [c32fd_pkg::LENGTH_BITS-1:0] left_dec;
  logic        go_idle;
  c32fd_pkg::status_e code;

  assign b        = item_i.in_byte;
  assign crc_next = c32fd_pkg::crc_byte(crc_q, b);
  assign len_full = {b, length_q[23:0]};
  assign rx_full  = {b, rx_crc_q[31:8]};
  // header bytes 9..12 land in length lanes 0..3
  assign len_lane = cnt_q[1:0] - 2'd1;
  assign left_dec = left_q - {{(c32fd_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};

  // next state and result for the held item
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    magic_d   = magic_q;
    version_d = version_q;
    type_d    = type_q;
    length_d  = length_q;
    left_d    = left_q;
    crc_d     = crc_q;
    rx_crc_d  = rx_crc_q;
    go_idle   = 1'b0;
    code      = c32fd_pkg::ST_OK;
    res_valid_o          = 1'b0;
    res_o.out_kind       = c32fd_pkg::KIND_PAYLOAD;
    res_o.out_byte       = 8'd0;
    res_o.last_payload   = 1'b0;
    res_o.status         = c32fd_pkg::ST_OK;

    if (item_i.action == c32fd_pkg::ACT_END) begin
      go_idle = 1'b1;
      code    = (phase_q == PH_HEADER) ? c32fd_pkg::ST_TRUNC_HDR : c32fd_pkg::ST_TRUNC_FRM;
    end else begin
      case (phase_q)
        PH_HEADER: begin
          crc_d = crc_next;
          cnt_d = cnt_q + 4'd1;
          if (cnt_q < 4'd4) begin
            magic_d = {b, magic_q[31:8]};
          end else if (cnt_q < 4'd8) begin
            version_d = {b, version_q[31:8]};
          end else if (cnt_q == 4'd8) begin
            type_d = b;
          end else begin
            length_d[8*len_lane +: 8] = b;
          end
          // header complete: checks in priority order
          if (cnt_q == c32fd_pkg::HDR_LAST) begin
            cnt_d = 4'd0;
            if (magic_q != cfg_i.frame_magic) begin
              go_idle = 1'b1;
              code    = c32fd_pkg::ST_BAD_MAGIC;
            end else if (version_q != cfg_i.protocol_version) begin
              go_idle = 1'b1;
              code    = c32fd_pkg::ST_BAD_VER;
            end else if (type_q > cfg_i.highest_type) begin
              go_idle = 1'b1;
              code    = c32fd_pkg::ST_BAD_TYPE;
            end else if (len_full > {8'd0, cfg_i.max_payload} ||
                         len_full > c32fd_pkg::LEN_LIMIT) begin
              go_idle = 1'b1;
              code    = c32fd_pkg::ST_OVERSIZED;
            end else begin
              left_d  = len_full[c32fd_pkg::LENGTH_BITS-1:0];
              phase_d = (len_full[c32fd_pkg::LENGTH_BITS-1:0] == '0) ? PH_CHECK : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_d              = crc_next;
          left_d             = left_dec;
          res_valid_o        = 1'b1;
          res_o.out_kind     = c32fd_pkg::KIND_PAYLOAD;
          res_o.out_byte     = b;
          res_o.last_payload = (left_dec == '0);
          if (left_dec == '0) begin
            phase_d = PH_CHECK;
            cnt_d   = 4'd0;
          end
        end
        PH_CHECK: begin
          rx_crc_d = rx_full;
          cnt_d    = cnt_q + 4'd1;
          if (cnt_q[1:0] == c32fd_pkg::CRC_LAST[1:0]) begin
            go_idle = 1'b1;
            code    = (rx_full != (crc_q ^ c32fd_pkg::ALL_ONES)) ?
                      c32fd_pkg::ST_CRC_ERR : c32fd_pkg::ST_OK;
          end
        end
        default: begin
          go_idle = 1'b1;
          code    = c32fd_pkg::ST_TRUNC_FRM;
        end
      endcase
    end

    // status result reports type and length gathered so far
    res_o.msg_type       = type_d;
    res_o.payload_length = length_d[23:0];
    if (go_idle) begin
      res_valid_o        = 1'b1;
      res_o.out_kind     = c32fd_pkg::KIND_STATUS;
      res_o.out_byte     = 8'd0;
      res_o.last_payload = 1'b0;
      res_o.status       = code;
      phase_d   = PH_HEADER;
      cnt_d     = 4'd0;
      magic_d   = 32'd0;
      version_d = 32'd0;
      type_d    = 8'd0;
      length_d  = 32'd0;
      left_d    = '0;
      crc_d     = c32fd_pkg::ALL_ONES;
      rx_crc_d  = 32'd0;
    end
  end

  // frame state, updated when the held item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      cnt_q     <= 4'd0;
      magic_q   <= 32'd0;
      version_q <= 32'd0;
      type_q    <= 8'd0;
      length_q  <= 32'd0;
      left_q    <= '0;
      crc_q     <= c32fd_pkg::ALL_ONES;
      rx_crc_q  <= 32'd0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      magic_q   <= magic_d;
      version_q <= version_d;
      type_q    <= type_d;
      length_q  <= length_d;
      left_q    <= left_d;
      crc_q     <= crc_d;
      rx_crc_q  <= rx_crc_d;
    end
  end

endmodule

### sv/c32fd_out_stage.sv
// c32fd_out_stage: result register that drives the output stream
// depends on c32fd_pkg
module c32fd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  logic                res_valid_i,
  input  c32fd_pkg::result_t  res_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output c32fd_pkg::result_t  out_o
);

  logic               valid_q;
  c32fd_pkg::result_t res_q;

  // the held item moves on when the result register is free this cycle
  assign advance_o = item_valid_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

### sv/crc32_frame_deframer.sv
// crc32_frame_deframer: an accepted byte or end event passes the input register, then the
// result register, before any result it yields is valid on the output port; one byte or end
// event is taken every cycle, set by the byte-wide crc update and header checks between the
// two registers; the input stalls only while a held result waits on a low m_axis_tready.
// Reset (rst_ni low, asynchronous) empties both registers, returns the parser to the
// header phase with the crc at all ones, and loads the register defaults.
module crc32_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_byte, msg_type, payload_length, status, zero pad
  output logic        m_axis_tlast,   // last_payload
  output logic        m_axis_tuser    // out_kind
);

  c32fd_pkg::cfg_t    cfg;
  c32fd_pkg::item_t   in_item;
  c32fd_pkg::item_t   item;
  c32fd_pkg::result_t res;
  c32fd_pkg::result_t out;
  logic               item_valid;
  logic               res_valid;
  logic               advance;

  assign in_item.action  = s_axis_tuser;
  assign in_item.in_byte = s_axis_tdata;

  c32fd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  c32fd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .advance_i    (advance)
  );

  c32fd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .advance_i   (advance),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  c32fd_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .advance_o    (advance),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (out)
  );

  // output packing
  assign m_axis_tdata = {5'd0, out.status, out.payload_length, out.msg_type, out.out_byte};
  assign m_axis_tlast = out.last_payload;
  assign m_axis_tuser = out.out_kind;

  // a status result never carries payload byte or last marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == c32fd_pkg::KIND_STATUS) |->
      !m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
    else $error("status result carries payload fields");

  // a payload result always reports status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == c32fd_pkg::KIND_PAYLOAD) |->
      (m_axis_tdata[42:40] == c32fd_pkg::ST_OK))
    else $error("payload result with nonzero status");

  // input side stalls only behind a held item and a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // a held item with a free result register always moves on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && !m_axis_tvalid |-> advance)
    else $error("held item not advanced");

endmodule

### tb/tb_crc32_frame_deframer.sv
// tb_crc32_frame_deframer: self-checking bench for the crc-32 frame deframer
// drives byte/end transfers, predicts results with its own parser model
// depends on c32fd_pkg and crc32_frame_deframer
`timescale 1ns / 1ps

module tb_crc32_frame_deframer;
  import c32fd_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1450;
  localparam int unsigned QUIET_FROM    = 1250;
  localparam int unsigned CFG_EVERY     = 240;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_BODY      = 12;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_PAY,
    PH_CRC
  } parse_phase_e;

  // parser model and queue of results still due from the block
  class frame_scoreboard;
    cfg_t         regs;
    parse_phase_e phase;
    logic [4:0]   byte_cnt;
    logic [31:0]  magic_acc;
    logic [31:0]  ver_acc;
    logic [7:0]   type_acc;
    logic [31:0]  len_acc;
    logic [23:0]  body_left;
    logic [31:0]  crc_acc;
    logic [31:0]  rx_crc;
    result_t      due_results[$];
    int unsigned  mismatches;

    function new();
      regs.frame_magic      = 32'd0;
      regs.protocol_version = 32'd1;
      regs.max_payload      = 24'd65536;
      regs.highest_type     = 8'd255;
      mismatches            = 0;
      restart();
    endfunction

    // bitwise reflected crc-32, lsb of the byte first
    static function logic [31:0] crc32_step(logic [31:0] c, logic [7:0] d);
      logic fb;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ d[k];
        c  = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void restart();
      phase     = PH_HDR;
      byte_cnt  = '0;
      magic_acc = '0;
      ver_acc   = '0;
      type_acc  = '0;
      len_acc   = '0;
      body_left = '0;
      crc_acc   = ALL_ONES;
      rx_crc    = '0;
    endfunction

    function void queue_status(status_e code);
      result_t r;
      r.out_kind       = KIND_STATUS;
      r.out_byte       = '0;
      r.msg_type       = type_acc;
      r.payload_length = len_acc[23:0];
      r.last_payload   = 1'b0;
      r.status         = code;
      due_results = {due_results, r};
      restart();
    endfunction

    // advance the parser by one accepted transfer
    function void take_input(logic act, logic [7:0] b);
      result_t    r;
      logic [4:0] i;
      if (act == ACT_END) begin
        if (phase == PH_HDR) queue_status(ST_TRUNC_HDR);
        else queue_status(ST_TRUNC_FRM);
        return;
      end
      case (phase)
        PH_HDR: begin
          crc_acc = crc32_step(crc_acc, b);
          i = byte_cnt;
          if (i < 4) magic_acc[8*i +: 8] = b;
          else if (i < 8) ver_acc[8*(i-4) +: 8] = b;
          else if (i == 8) type_acc = b;
          else len_acc[8*(i-9) +: 8] = b;
          byte_cnt = i + 5'd1;
          if (byte_cnt == HDR_BYTES) begin
            byte_cnt = '0;
            // header checks in priority order
            if (magic_acc != regs.frame_magic) queue_status(ST_BAD_MAGIC);
            else if (ver_acc != regs.protocol_version) queue_status(ST_BAD_VER);
            else if (type_acc > regs.highest_type) queue_status(ST_BAD_TYPE);
            else if (len_acc > {8'd0, regs.max_payload} || len_acc > LEN_LIMIT)
              queue_status(ST_OVERSIZED);
            else begin
              body_left = len_acc[23:0];
              phase     = (body_left == '0) ? PH_CRC : PH_PAY;
            end
          end
        end
        PH_PAY: begin
          crc_acc = crc32_step(crc_acc, b);
          if (body_left != '0) body_left = body_left - 24'd1;
          r.out_kind       = KIND_PAYLOAD;
          r.out_byte       = b;
          r.msg_type       = type_acc;
          r.payload_length = len_acc[23:0];
          r.last_payload   = (body_left == '0);
          r.status         = ST_OK;
          due_results = {due_results, r};
          if (body_left == '0) begin
            phase    = PH_CRC;
            byte_cnt = '0;
          end
        end
        default: begin
          i = byte_cnt & 5'd3;
          rx_crc[8*i +: 8] = b;
          byte_cnt = i + 5'd1;
          if (byte_cnt == 5'd4) begin
            if (rx_crc != ~crc_acc) queue_status(ST_CRC_ERR);
            else queue_status(ST_OK);
          end
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // compare one output transfer with the oldest due result
    function void check_result(logic kind, logic [47:0] data, logic last);
      result_t w;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d data %0h last %0d", kind, data, last);
        mismatches++;
        return;
      end
      w = due_results.pop_front();
      cmp_field("out_kind", w.out_kind, kind);
      cmp_field("out_byte", w.out_byte, data[7:0]);
      cmp_field("msg_type", w.msg_type, data[15:8]);
      cmp_field("payload_length", w.payload_length, data[39:16]);
      cmp_field("last_payload", w.last_payload, last);
      cmp_field("status", w.status, data[42:40]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // in_byte
  logic        s_axis_tuser;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // out_byte, msg_type, payload_length, status, zero pad
  logic        m_axis_tlast;   // last_payload
  logic        m_axis_tuser;   // out_kind

  frame_scoreboard sb = new();
  cfg_t            cfg_now;
  logic [7:0]      frame_bytes[$];
  bit              gaps_on;
  int unsigned     items_sent;
  int unsigned     cycle_cnt;
  int unsigned     stall_left;

  crc32_frame_deframer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver with random stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(1, 7) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // one input transfer, optionally after an idle burst; returns at a falling edge
  task automatic send_item(input logic act, input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_input(act, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(ACT_BYTE, frame_bytes[i]);
  endtask

  task automatic send_end();
    send_item(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  // hold the sender until every due result is back, then let the pipe settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] magic, input logic [31:0] ver,
                              input logic [23:0] maxp, input logic [7:0] hi);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= REG_MAGIC;
    cfg_data_i <= magic;
    @(negedge clk_i);
    cfg_addr_i <= REG_VERSION;
    cfg_data_i <= ver;
    @(negedge clk_i);
    cfg_addr_i <= REG_MAX_LEN;
    cfg_data_i <= {8'd0, maxp};
    @(negedge clk_i);
    cfg_addr_i <= REG_HI_TYPE;
    cfg_data_i <= {24'd0, hi};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_now.frame_magic      = magic;
    cfg_now.protocol_version = ver;
    cfg_now.max_payload      = maxp;
    cfg_now.highest_type     = hi;
    sb.regs = cfg_now;
  endtask

  // first two rounds hit the extremes, later ones mix extremes and random values
  task automatic reprogram(input int unsigned round);
    logic [31:0] magic;
    logic [31:0] ver;
    logic [23:0] maxp;
    logic [7:0]  hi;
    if (round == 0) begin
      program_regs(32'hFFFF_FFFF, 32'd0, 24'd0, 8'd0);
    end else if (round == 1) begin
      program_regs(32'd0, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'd255);
    end else begin
      magic = $urandom;
      ver   = ($urandom_range(0, 3) == 0) ? 32'd1 : $urandom;
      case ($urandom_range(0, 5))
        0:       maxp = 24'd0;
        1:       maxp = 24'd1;
        2:       maxp = 24'($urandom_range(2, 16));
        3:       maxp = 24'd65536;
        4:       maxp = 24'hFF_FFFF;
        default: maxp = 24'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0:       hi = 8'd0;
        1:       hi = 8'd255;
        default: hi = 8'($urandom);
      endcase
      program_regs(magic, ver, maxp, hi);
    end
  endtask

  function automatic void push_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) frame_bytes = {frame_bytes, w[8*k +: 8]};
  endfunction

  function automatic void start_frame(input logic [31:0] magic, input logic [31:0] ver,
                                      input logic [7:0] typ, input logic [31:0] len);
    frame_bytes.delete();
    push_word(magic);
    push_word(ver);
    frame_bytes = {frame_bytes, typ};
    push_word(len);
  endfunction

  function automatic void add_body(input int unsigned n);
    repeat (n) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
  endfunction

  // trailer over everything gathered so far, one bit flipped when corrupt
  function automatic void add_crc(input bit corrupt);
    logic [31:0] c;
    c = ALL_ONES;
    foreach (frame_bytes[i]) c = frame_scoreboard::crc32_step(c, frame_bytes[i]);
    c = ~c;
    if (corrupt) c = c ^ (32'd1 << $urandom_range(0, 31));
    push_word(c);
  endfunction

  // mostly short payloads, sometimes a longer one, never above the limit
  function automatic int unsigned pick_len();
    int unsigned cap;
    cap = ($urandom_range(0, 9) == 0) ? 40 : MAX_BODY;
    if (cfg_now.max_payload < cap) cap = cfg_now.max_payload;
    return $urandom_range(0, cap);
  endfunction

  function automatic logic [7:0] pick_type();
    return 8'($urandom_range(0, cfg_now.highest_type));
  endfunction

  task automatic good_frame(input bit corrupt);
    int unsigned len;
    len = pick_len();
    start_frame(cfg_now.frame_magic, cfg_now.protocol_version, pick_type(), len);
    add_body(len);
    add_crc(corrupt);
    send_bytes(frame_bytes.size());
  endtask

  // one or more header faults at once, so the check priority is exercised
  task automatic header_fault();
    bit          fm;
    bit          fv;
    bit          ft;
    bit          fo;
    logic [31:0] magic;
    logic [31:0] ver;
    logic [7:0]  typ;
    logic [31:0] len;
    fm = $urandom_range(0, 1);
    fv = $urandom_range(0, 1);
    ft = (cfg_now.highest_type != 8'd255) && $urandom_range(0, 1);
    fo = $urandom_range(0, 1);
    if (!(fm || fv || ft || fo)) fm = 1'b1;
    magic = fm ? cfg_now.frame_magic ^ (32'd1 << $urandom_range(0, 31)) : cfg_now.frame_magic;
    ver   = fv ? cfg_now.protocol_version ^ (32'd1 << $urandom_range(0, 31))
               : cfg_now.protocol_version;
    typ   = ft ? 8'($urandom_range(cfg_now.highest_type + 1, 255)) : pick_type();
    if (!fo) len = pick_len();
    else if (cfg_now.max_payload == 24'hFF_FFFF || $urandom_range(0, 1) == 0)
      len = {8'($urandom_range(1, 255)), 24'($urandom)};
    else
      len = {8'd0, cfg_now.max_payload} + 32'($urandom_range(1, 4));
    start_frame(magic, ver, typ, len);
    send_bytes(HDR_BYTES);
  endtask

  // frame cut short anywhere before its last byte, then end of stream
  task automatic truncated_frame();
    int unsigned hdr_len;
    int unsigned body;
    hdr_len = ($urandom_range(0, 3) == 0) ? cfg_now.max_payload : pick_len();
    body    = (hdr_len > MAX_BODY) ? MAX_BODY : hdr_len;
    start_frame(cfg_now.frame_magic, cfg_now.protocol_version, pick_type(), hdr_len);
    add_body(body);
    if (hdr_len <= MAX_BODY) add_crc(1'b0);
    send_bytes($urandom_range(0, frame_bytes.size() - 1));
    send_end();
  endtask

  task automatic noise_burst();
    frame_bytes.delete();
    add_body($urandom_range(1, 20));
    send_bytes(frame_bytes.size());
    send_end();
  endtask

  initial begin
    int unsigned cfg_round;
    int unsigned next_cfg_at;
    int unsigned pick;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_MAGIC;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_BYTE;
    m_axis_tready = 1'b0;
    gaps_on       = 1'b1;
    items_sent    = 0;
    cycle_cnt     = 0;
    stall_left    = 0;
    cfg_round     = 0;
    next_cfg_at   = 0;
    cfg_now       = sb.regs;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: end with nothing gathered, empty good frame, bad version header
    send_end();
    start_frame(32'd0, 32'd1, 8'd255, 32'd0);
    add_crc(1'b0);
    send_bytes(frame_bytes.size());
    start_frame(32'd0, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF);
    send_bytes(HDR_BYTES);
    wait_drained();

    // random frames, with a register change at idle points
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_cfg_at) begin
        wait_drained();
        reprogram(cfg_round);
        cfg_round++;
        next_cfg_at = items_sent + CFG_EVERY;
      end
      if (items_sent >= QUIET_FROM) gaps_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 60) good_frame(1'b0);
      else if (pick < 70) good_frame(1'b1);
      else if (pick < 80) header_fault();
      else if (pick < 90) truncated_frame();
      else if (pick < 95) send_end();
      else noise_burst();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/c32fd_pkg.sv
sv/c32fd_cfg_regs.sv
sv/c32fd_in_stage.sv
sv/c32fd_parser.sv
sv/c32fd_out_stage.sv
sv/crc32_frame_deframer.sv
tb/tb_crc32_frame_deframer.sv
